### hw/rtl/quaternion_slerp_assert.svh
// Assertion macros for the quaternion slerp block; they sample on clk and idle under arst_n.
`ifndef QUATERNION_SLERP_ASSERT_SVH
`define QUATERNION_SLERP_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define QSL_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause.
`define QSL_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/qsl_pkg.sv
// Types and fixed-point constants shared by the quaternion slerp pipeline.
`timescale 1ns / 1ps
package qsl_pkg;

	localparam int COMPONENT_BITS = 16;
	localparam int FRAC_BITS      = COMPONENT_BITS - 2;
	localparam int T_W            = 17;
	localparam int TF_W           = 16;
	localparam int DOT_W          = 36;
	localparam int PROD_SHL       = (2 * FRAC_BITS <= 30) ? 30 - 2 * FRAC_BITS : 0;
	localparam int PROD_SHR       = (2 * FRAC_BITS > 30) ? 2 * FRAC_BITS - 30 : 0;
	localparam int PROD_W         = 2 * COMPONENT_BITS + PROD_SHL;
	localparam int C_W            = 30;
	localparam int REM_W          = C_W + 2;
	localparam int RAD_W          = 2 * C_W;
	localparam int W_W            = 32;
	localparam int SQ_STEPS       = C_W;
	localparam int DIV_STEPS      = W_W;
	localparam int DIV_D_W        = C_W + DIV_STEPS;
	localparam int LEVELS         = TF_W;

	localparam logic signed [DOT_W-1:0] DOT_ONE  = DOT_W'(64'sd1073741824);
	localparam logic signed [DOT_W-1:0] NEAR_ONE = DOT_W'(64'sd1073731072);
	localparam logic [W_W-1:0]          W_ONE    = W_W'(64'd1073741824);
	localparam logic [T_W-1:0]          T_ONE    = T_W'(32'd65536);

	typedef logic signed [COMPONENT_BITS-1:0] comp_t;

	typedef struct packed {
		logic [T_W-1:0] blend_t;
		comp_t          first_w;
		comp_t          first_x;
		comp_t          first_y;
		comp_t          first_z;
		comp_t          second_w;
		comp_t          second_x;
		comp_t          second_y;
		comp_t          second_z;
	} qsl_item_t;

	typedef struct packed {
		comp_t blend_w;
		comp_t blend_x;
		comp_t blend_y;
		comp_t blend_z;
	} qsl_result_t;

	// Everything one transaction carries down the bisection levels
	typedef struct packed {
		logic                               ident;
		logic                               slerp;
		logic                               tone;
		logic [T_W-1:0]                     t;
		logic [TF_W-1:0]                    tsh;
		logic [3:0][COMPONENT_BITS-1:0]     a;
		logic [3:0][COMPONENT_BITS:0]       b;
		logic [W_W-1:0]                     lo1;
		logic [W_W-1:0]                     lo2;
		logic [W_W-1:0]                     hi1;
		logic [W_W-1:0]                     hi2;
		logic [C_W-1:0]                     c;
	} qsl_carry_t;

	// Clamp a wide signed value to the component range
	function automatic comp_t sat_comp(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (COMPONENT_BITS - 1)) - 64'sd1;
		lo = -(64'sd1 <<< (COMPONENT_BITS - 1));
		if (v > hi) begin
			return hi[COMPONENT_BITS-1:0];
		end else if (v < lo) begin
			return lo[COMPONENT_BITS-1:0];
		end
		return v[COMPONENT_BITS-1:0];
	endfunction

endpackage

### hw/rtl/qsl_level.sv
// One bisection level of the slerp weights: half-angle square root, then two weight divisions.
`timescale 1ns / 1ps
module qsl_level (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_v,
	input  qsl_pkg::qsl_carry_t in_c,
	output logic                out_v,
	output qsl_pkg::qsl_carry_t out_c
);
	import qsl_pkg::*;

	// square root pipe, one root bit per stage; entry 0 is the level input
	logic             sq_v_s    [0:SQ_STEPS];
	qsl_carry_t       sq_c_s    [0:SQ_STEPS];
	logic [RAD_W-1:0] sq_rad_s  [0:SQ_STEPS];
	logic [REM_W-1:0] sq_rem_s  [0:SQ_STEPS];
	logic [C_W-1:0]   sq_root_s [0:SQ_STEPS];

	assign sq_v_s[0]    = in_v;
	assign sq_c_s[0]    = in_c;
	assign sq_rad_s[0]  = {1'b1, in_c.c, {(RAD_W - C_W - 1){1'b0}}};
	assign sq_rem_s[0]  = '0;
	assign sq_root_s[0] = '0;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		logic             fits;

		assign rem_sh = {sq_rem_s[k][REM_W-3:0], sq_rad_s[k][RAD_W-1 -: 2]};
		assign trial  = {sq_root_s[k], 2'b01};
		assign fits   = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			sq_c_s[k+1]    <= sq_c_s[k];
			sq_rad_s[k+1]  <= sq_rad_s[k] << 2;
			sq_rem_s[k+1]  <= fits ? rem_sh - trial : rem_sh;
			sq_root_s[k+1] <= {sq_root_s[k][C_W-2:0], fits};
		end
	end

	// form both dividends and take the new half-angle cosine
	logic                 pr_v_s;
	qsl_carry_t           pr_c_s;
	logic [DIV_D_W-1:0]   pr_d1_s;
	logic [DIV_D_W-1:0]   pr_d2_s;
	logic [W_W:0]         sum1;
	logic [W_W:0]         sum2;
	qsl_carry_t           pr_c_d;

	always_comb begin
		sum1   = {1'b0, sq_c_s[SQ_STEPS].lo1} + {1'b0, sq_c_s[SQ_STEPS].hi1};
		sum2   = {1'b0, sq_c_s[SQ_STEPS].lo2} + {1'b0, sq_c_s[SQ_STEPS].hi2};
		pr_c_d = sq_c_s[SQ_STEPS];
		pr_c_d.c = sq_root_s[SQ_STEPS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pr_v_s <= 1'b0;
		end else begin
			pr_v_s <= sq_v_s[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		pr_c_s  <= pr_c_d;
		pr_d1_s <= {sum1, {(DIV_D_W - W_W - 1){1'b0}}}
			+ DIV_D_W'(sq_root_s[SQ_STEPS] >> 1);
		pr_d2_s <= {sum2, {(DIV_D_W - W_W - 1){1'b0}}}
			+ DIV_D_W'(sq_root_s[SQ_STEPS] >> 1);
	end

	// restoring division, one quotient bit per stage for both weights
	logic                 dv_v_s  [0:DIV_STEPS];
	qsl_carry_t           dv_c_s  [0:DIV_STEPS];
	logic [C_W-1:0]       dv_r1_s [0:DIV_STEPS];
	logic [C_W-1:0]       dv_r2_s [0:DIV_STEPS];
	logic [DIV_STEPS-1:0] dv_x1_s [0:DIV_STEPS];
	logic [DIV_STEPS-1:0] dv_x2_s [0:DIV_STEPS];
	logic [W_W-1:0]       dv_q1_s [0:DIV_STEPS];
	logic [W_W-1:0]       dv_q2_s [0:DIV_STEPS];

	assign dv_v_s[0]  = pr_v_s;
	assign dv_c_s[0]  = pr_c_s;
	assign dv_r1_s[0] = pr_d1_s[DIV_D_W-1 -: C_W];
	assign dv_r2_s[0] = pr_d2_s[DIV_D_W-1 -: C_W];
	assign dv_x1_s[0] = pr_d1_s[DIV_STEPS-1:0];
	assign dv_x2_s[0] = pr_d2_s[DIV_STEPS-1:0];
	assign dv_q1_s[0] = '0;
	assign dv_q2_s[0] = '0;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [C_W:0] n1;
		logic [C_W:0] n2;
		logic [C_W:0] dvs;
		logic         ge1;
		logic         ge2;

		assign dvs = {1'b0, dv_c_s[k].c};
		assign n1  = {dv_r1_s[k], dv_x1_s[k][DIV_STEPS-1]};
		assign n2  = {dv_r2_s[k], dv_x2_s[k][DIV_STEPS-1]};
		assign ge1 = n1 >= dvs;
		assign ge2 = n2 >= dvs;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dv_c_s[k+1]  <= dv_c_s[k];
			dv_r1_s[k+1] <= ge1 ? C_W'(n1 - dvs) : n1[C_W-1:0];
			dv_r2_s[k+1] <= ge2 ? C_W'(n2 - dvs) : n2[C_W-1:0];
			dv_x1_s[k+1] <= dv_x1_s[k] << 1;
			dv_x2_s[k+1] <= dv_x2_s[k] << 1;
			dv_q1_s[k+1] <= {dv_q1_s[k][W_W-2:0], ge1};
			dv_q2_s[k+1] <= {dv_q2_s[k][W_W-2:0], ge2};
		end
	end

	// keep the upper half on a set fraction bit, else the lower half
	assign out_v = dv_v_s[DIV_STEPS];

	always_comb begin
		out_c = dv_c_s[DIV_STEPS];
		if (dv_c_s[DIV_STEPS].tsh[TF_W-1]) begin
			out_c.lo1 = dv_q1_s[DIV_STEPS];
			out_c.lo2 = dv_q2_s[DIV_STEPS];
		end else begin
			out_c.hi1 = dv_q1_s[DIV_STEPS];
			out_c.hi2 = dv_q2_s[DIV_STEPS];
		end
		out_c.tsh = {dv_c_s[DIV_STEPS].tsh[TF_W-2:0], 1'b0};
	end

endmodule

### hw/rtl/quaternion_slerp.sv
// Quaternion slerp top level: dot product, 16 bisection levels, weighting and saturation.
// A result is strobed on done once the transaction that start brought in has passed stages 1-3, the levels, E1 and E2.
// Throughput: one transaction per cycle; busy stays low since every stage advances each cycle.
// Depth is set by the bisection: per level 30 square root stages, 1 prep, 32 divide stages.
// Reset clears only the valid bits; no result is strobed until a transaction has passed through.
`timescale 1ns / 1ps
module quaternion_slerp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  qsl_pkg::qsl_item_t   item,
	output logic                 done,
	output qsl_pkg::qsl_result_t result
);
	import qsl_pkg::*;

	localparam int P1_W  = W_W + 1 + COMPONENT_BITS;
	localparam int P2_W  = W_W + 2 + COMPONENT_BITS;
	localparam int LIN_W = COMPONENT_BITS + 2 + T_W + 1;
	localparam int ACC_W = W_W + COMPONENT_BITS + 3;

	// the pipeline never stalls
	assign busy = 1'b0;

	// stage 1: clamp the fraction and form the scaled component products
	logic                            s1_v_s;
	logic [T_W-1:0]                  s1_t_s;
	logic [3:0][COMPONENT_BITS-1:0]  s1_a_s;
	logic [3:0][COMPONENT_BITS:0]    s1_b_s;
	logic signed [DOT_W-1:0]         s1_p_s [0:3];
	logic [3:0][COMPONENT_BITS-1:0]  in_a;
	logic [3:0][COMPONENT_BITS-1:0]  in_b;
	logic signed [PROD_W-1:0]        prod [0:3];
	logic signed [PROD_W-1:0]        scaled [0:3];

	always_comb begin
		in_a[0] = item.first_w;
		in_a[1] = item.first_x;
		in_a[2] = item.first_y;
		in_a[3] = item.first_z;
		in_b[0] = item.second_w;
		in_b[1] = item.second_x;
		in_b[2] = item.second_y;
		in_b[3] = item.second_z;
		for (int i = 0; i < 4; i++) begin
			prod[i]   = PROD_W'($signed(in_a[i])) * PROD_W'($signed(in_b[i]));
			scaled[i] = (prod[i] <<< PROD_SHL) >>> PROD_SHR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s <= 1'b0;
		end else begin
			s1_v_s <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		s1_t_s <= (item.blend_t > T_ONE) ? T_ONE : item.blend_t;
		for (int i = 0; i < 4; i++) begin
			s1_a_s[i] <= in_a[i];
			s1_b_s[i] <= {in_b[i][COMPONENT_BITS-1], in_b[i]};
			s1_p_s[i] <= DOT_W'(scaled[i]);
		end
	end

	// stage 2: sum the dot product
	logic                            s2_v_s;
	logic [T_W-1:0]                  s2_t_s;
	logic [3:0][COMPONENT_BITS-1:0]  s2_a_s;
	logic [3:0][COMPONENT_BITS:0]    s2_b_s;
	logic signed [DOT_W-1:0]         s2_dot_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_s <= 1'b0;
		end else begin
			s2_v_s <= s1_v_s;
		end
	end

	always_ff @(posedge clk) begin
		s2_t_s   <= s1_t_s;
		s2_a_s   <= s1_a_s;
		s2_b_s   <= s1_b_s;
		s2_dot_s <= s1_p_s[0] + s1_p_s[1] + s1_p_s[2] + s1_p_s[3];
	end

	// stage 3: pick the path, flip to the short arc, seed the bisection
	logic                    s3_v_s;
	qsl_carry_t              s3_c_s;
	qsl_carry_t              s3_c_d;
	logic                    dot_neg;
	logic signed [DOT_W-1:0] dot_abs;

	always_comb begin
		dot_neg       = s2_dot_s < 0;
		dot_abs       = dot_neg ? -s2_dot_s : s2_dot_s;
		s3_c_d.ident  = s2_dot_s == DOT_ONE;
		s3_c_d.slerp  = !(s2_dot_s == DOT_ONE) && (dot_abs < NEAR_ONE);
		s3_c_d.tone   = s2_t_s == T_ONE;
		s3_c_d.t      = s2_t_s;
		s3_c_d.tsh    = s2_t_s[TF_W-1:0];
		s3_c_d.a      = s2_a_s;
		for (int i = 0; i < 4; i++) begin
			s3_c_d.b[i] = dot_neg ? -s2_b_s[i] : s2_b_s[i];
		end
		s3_c_d.lo1    = W_ONE;
		s3_c_d.lo2    = '0;
		s3_c_d.hi1    = '0;
		s3_c_d.hi2    = W_ONE;
		s3_c_d.c      = s3_c_d.slerp ? dot_abs[C_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v_s <= 1'b0;
		end else begin
			s3_v_s <= s2_v_s;
		end
	end

	always_ff @(posedge clk) begin
		s3_c_s <= s3_c_d;
	end

	// bisection levels, most significant fraction bit first
	logic       lv_v [0:LEVELS];
	qsl_carry_t lv_c [0:LEVELS];

	assign lv_v[0] = s3_v_s;
	assign lv_c[0] = s3_c_s;

	for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
		qsl_level u_level (
			.clk    (clk),
			.arst_n (arst_n),
			.in_v   (lv_v[k]),
			.in_c   (lv_c[k]),
			.out_v  (lv_v[k+1]),
			.out_c  (lv_c[k+1])
		);
	end

	// stage E1: weight products and the linear blend product
	logic                     e1_v_s;
	qsl_carry_t               e1_c_s;
	logic signed [P1_W-1:0]   e1_p1_s  [0:3];
	logic signed [P2_W-1:0]   e1_p2_s  [0:3];
	logic signed [LIN_W-1:0]  e1_lin_s [0:3];
	logic [W_W-1:0]           w1;
	logic [W_W-1:0]           w2;
	logic signed [COMPONENT_BITS+1:0] diff [0:3];

	always_comb begin
		w1 = lv_c[LEVELS].tone ? '0 : lv_c[LEVELS].lo1;
		w2 = lv_c[LEVELS].tone ? W_ONE : lv_c[LEVELS].lo2;
		for (int i = 0; i < 4; i++) begin
			diff[i] = $signed({lv_c[LEVELS].b[i][COMPONENT_BITS], lv_c[LEVELS].b[i]})
				- $signed({{2{lv_c[LEVELS].a[i][COMPONENT_BITS-1]}}, lv_c[LEVELS].a[i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_v_s <= 1'b0;
		end else begin
			e1_v_s <= lv_v[LEVELS];
		end
	end

	always_ff @(posedge clk) begin
		e1_c_s <= lv_c[LEVELS];
		for (int i = 0; i < 4; i++) begin
			e1_p1_s[i]  <= $signed({1'b0, w1}) * $signed(lv_c[LEVELS].a[i]);
			e1_p2_s[i]  <= $signed({1'b0, w2}) * $signed(lv_c[LEVELS].b[i]);
			e1_lin_s[i] <= diff[i] * $signed({1'b0, lv_c[LEVELS].t});
		end
	end

	// stage E2: round, select the path and saturate
	logic                     e2_v_s;
	qsl_result_t              e2_res_s;
	logic signed [ACC_W-1:0]  acc  [0:3];
	logic signed [ACC_W-1:0]  acc_r [0:3];
	logic signed [LIN_W-1:0]  lin_r [0:3];
	logic signed [63:0]       lin_sum [0:3];
	comp_t                    res [0:3];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			acc[i]     = ACC_W'(e1_p1_s[i]) + ACC_W'(e1_p2_s[i]);
			acc_r[i]   = (acc[i] + (ACC_W'(1) <<< 29)) >>> 30;
			lin_r[i]   = (e1_lin_s[i] + (LIN_W'(1) <<< 15)) >>> 16;
			lin_sum[i] = 64'($signed(e1_c_s.a[i])) + 64'(lin_r[i]);
			if (e1_c_s.ident) begin
				res[i] = $signed(e1_c_s.a[i]);
			end else if (e1_c_s.slerp) begin
				res[i] = sat_comp(64'(acc_r[i]));
			end else begin
				res[i] = sat_comp(lin_sum[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e2_v_s <= 1'b0;
		end else begin
			e2_v_s <= e1_v_s;
		end
	end

	always_ff @(posedge clk) begin
		e2_res_s.blend_w <= res[0];
		e2_res_s.blend_x <= res[1];
		e2_res_s.blend_y <= res[2];
		e2_res_s.blend_z <= res[3];
	end

	assign done   = e2_v_s;
	assign result = e2_res_s;

	// checks on the pipeline's own logic
	`include "quaternion_slerp_assert.svh"

	`QSL_ASSERT_NEXT(a_sum_follows_product, s1_v_s, s2_v_s, "transaction lost before the dot sum")
	`QSL_ASSERT_SAME(a_path_exclusive, s3_v_s, !(s3_c_s.ident && s3_c_s.slerp), "two paths chosen")
	`QSL_ASSERT_NEXT(a_ident_passes, e1_v_s && e1_c_s.ident,
		done && (result.blend_w == $past(e1_c_s.a[0])), "identical keys not passed through")

endmodule
